// ----- hdl/aat_pkg.sv -----
`timescale 1ns / 1ps
// aat_pkg: shared types, register and mode codes, saturation helper
// for the box transform pipeline; no dependencies
package aat_pkg;

  typedef logic signed [31:0] fix_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [65:0] acc_t;

  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_POSITION = 2'd1;
  localparam logic [1:0] MODE_FULL     = 2'd2;

  localparam logic [2:0] REG_CULL_MODE   = 3'd0;
  localparam logic [2:0] REG_LOCAL_MIN_X = 3'd1;
  localparam logic [2:0] REG_LOCAL_MIN_Y = 3'd2;
  localparam logic [2:0] REG_LOCAL_MIN_Z = 3'd3;
  localparam logic [2:0] REG_LOCAL_MAX_X = 3'd4;
  localparam logic [2:0] REG_LOCAL_MAX_Y = 3'd5;
  localparam logic [2:0] REG_LOCAL_MAX_Z = 3'd6;

  localparam fix_t FIX_MAX = 32'sh7FFF_FFFF;
  localparam fix_t FIX_MIN = 32'sh8000_0000;

  typedef struct packed {
    fix_t m00;
    fix_t m01;
    fix_t m02;
    fix_t tx;
    fix_t m10;
    fix_t m11;
    fix_t m12;
    fix_t ty;
    fix_t m20;
    fix_t m21;
    fix_t m22;
    fix_t tz;
  } xform_t;

  typedef struct packed {
    fix_t world_min_x;
    fix_t world_min_y;
    fix_t world_min_z;
    fix_t world_max_x;
    fix_t world_max_y;
    fix_t world_max_z;
    logic box_empty;
  } box_t;

  typedef struct packed {
    logic [1:0] mode;
    fix_t [2:0] lo;
    fix_t [2:0] hi;
  } cfg_t;

  // per row and column: smallest and largest product over the two box bounds
  typedef struct packed {
    prod_t [2:0][2:0] lo_term;
    prod_t [2:0][2:0] hi_term;
    fix_t [2:0]       t;
  } span_t;

  function automatic fix_t sat32(input acc_t v);
    fix_t r;
    if (v > acc_t'(FIX_MAX)) begin
      r = FIX_MAX;
    end else if (v < acc_t'(FIX_MIN)) begin
      r = FIX_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/aat_cfg.sv -----
`timescale 1ns / 1ps
// aat_cfg: cull mode and local box registers behind the write channel
// depends on aat_pkg
module aat_cfg import aat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  logic [1:0] mode;
  fix_t [2:0] lo;
  fix_t [2:0] hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE;
      lo   <= '0;
      hi   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CULL_MODE:   mode  <= cfg_data[1:0];
        REG_LOCAL_MIN_X: lo[0] <= cfg_data;
        REG_LOCAL_MIN_Y: lo[1] <= cfg_data;
        REG_LOCAL_MIN_Z: lo[2] <= cfg_data;
        REG_LOCAL_MAX_X: hi[0] <= cfg_data;
        REG_LOCAL_MAX_Y: hi[1] <= cfg_data;
        REG_LOCAL_MAX_Z: hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.mode = mode;
  assign cfg.lo   = lo;
  assign cfg.hi   = hi;

endmodule

// ----- hdl/aat_corner_span.sv -----
`timescale 1ns / 1ps
// aat_corner_span: multiply stage and per-term min/max stage
// depends on aat_pkg
module aat_corner_span import aat_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   up_valid,
  output logic   up_ready,
  input  xform_t up_word,
  input  cfg_t   cfg,
  output logic   dn_valid,
  input  logic   dn_ready,
  output span_t  dn_word
);

  fix_t  m_in [3][3];
  fix_t  t_in [3];
  prod_t pa_next [3][3];
  prod_t pb_next [3][3];

  logic  a_valid;
  logic  b_valid;
  logic  en_a;
  logic  en_b;
  prod_t pa [3][3];
  prod_t pb [3][3];
  fix_t  ta [3];
  span_t span;

  assign en_b     = !b_valid || dn_ready;
  assign en_a     = !a_valid || en_b;
  assign up_ready = en_a;

  always_comb begin
    m_in[0][0] = up_word.m00; m_in[0][1] = up_word.m01; m_in[0][2] = up_word.m02;
    m_in[1][0] = up_word.m10; m_in[1][1] = up_word.m11; m_in[1][2] = up_word.m12;
    m_in[2][0] = up_word.m20; m_in[2][1] = up_word.m21; m_in[2][2] = up_word.m22;
    t_in[0] = up_word.tx;
    t_in[1] = up_word.ty;
    t_in[2] = up_word.tz;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pa_next[r][c] = $signed(m_in[r][c]) * $signed(cfg.lo[c]);
        pb_next[r][c] = $signed(m_in[r][c]) * $signed(cfg.hi[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && up_valid) begin
      pa <= pa_next;
      pb <= pb_next;
      ta <= t_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_valid) begin
      for (int r = 0; r < 3; r++) begin
        span.t[r] <= ta[r];
        for (int c = 0; c < 3; c++) begin
          if ($signed(pa[r][c]) < $signed(pb[r][c])) begin
            span.lo_term[r][c] <= pa[r][c];
            span.hi_term[r][c] <= pb[r][c];
          end else begin
            span.lo_term[r][c] <= pb[r][c];
            span.hi_term[r][c] <= pa[r][c];
          end
        end
      end
    end
  end

  assign dn_valid = b_valid;
  assign dn_word  = span;

endmodule

// ----- hdl/aat_round_sat.sv -----
`timescale 1ns / 1ps
// aat_round_sat: row sum with rounding stage, then translation, saturation
// and mode select into the output register; depends on aat_pkg
module aat_round_sat import aat_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  span_t up_word,
  input  cfg_t  cfg,
  output logic  dn_valid,
  input  logic  dn_ready,
  output box_t  dn_word
);

  localparam acc_t HALF = acc_t'(1) << (FRAC_BITS - 1);

  logic c_valid;
  logic d_valid;
  logic en_c;
  logic en_d;
  acc_t lo_sum [3];
  acc_t hi_sum [3];
  fix_t tc [3];
  fix_t wmin [3];
  fix_t wmax [3];
  logic empty_next;
  box_t box;

  assign en_d     = !d_valid || dn_ready;
  assign en_c     = !c_valid || en_d;
  assign up_ready = en_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en_c) begin
      c_valid <= up_valid;
    end
  end

  // floor((sum + half) / 2^frac) rounds to nearest, ties upward
  always_ff @(posedge clk) begin
    if (en_c && up_valid) begin
      for (int r = 0; r < 3; r++) begin
        lo_sum[r] <= acc_t'($signed(up_word.lo_term[r][0]))
                   + acc_t'($signed(up_word.lo_term[r][1]))
                   + acc_t'($signed(up_word.lo_term[r][2])) + HALF;
        hi_sum[r] <= acc_t'($signed(up_word.hi_term[r][0]))
                   + acc_t'($signed(up_word.hi_term[r][1]))
                   + acc_t'($signed(up_word.hi_term[r][2])) + HALF;
        tc[r]     <= up_word.t[r];
      end
    end
  end

  always_comb begin
    empty_next = 1'b0;
    for (int r = 0; r < 3; r++) begin
      wmin[r] = '0;
      wmax[r] = '0;
    end
    case (cfg.mode)
      MODE_POSITION: begin
        for (int r = 0; r < 3; r++) begin
          wmin[r] = sat32(acc_t'($signed(cfg.lo[r])) + acc_t'(tc[r]));
          wmax[r] = sat32(acc_t'($signed(cfg.hi[r])) + acc_t'(tc[r]));
        end
      end
      MODE_FULL: begin
        for (int r = 0; r < 3; r++) begin
          wmin[r] = sat32((lo_sum[r] >>> FRAC_BITS) + acc_t'(tc[r]));
          wmax[r] = sat32((hi_sum[r] >>> FRAC_BITS) + acc_t'(tc[r]));
        end
      end
      default: begin
        empty_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en_d) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d && c_valid) begin
      box.world_min_x <= wmin[0];
      box.world_min_y <= wmin[1];
      box.world_min_z <= wmin[2];
      box.world_max_x <= wmax[0];
      box.world_max_y <= wmax[1];
      box.world_max_z <= wmax[2];
      box.box_empty   <= empty_next;
    end
  end

  assign dn_valid = d_valid;
  assign dn_word  = box;

endmodule

// ----- hdl/aabb_affine_transform.sv -----
`timescale 1ns / 1ps
// aabb_affine_transform: top level, world-space box of a local box under
// one affine transform per word; depends on aat_pkg and the aat_* modules
//
// usage:
// - xform channel: one 3x4 affine matrix word (Q format with FRAC_BITS
//   fraction bits), valid/ready
// - box channel: one world box word per matrix word, in order, valid/ready
// - cfg channel: writes cull mode and local box bounds, always ready;
//   write only while no word is in flight
// - full mode: per axis, min and max of each matrix term over the two local
//   bounds are summed, so the eight corners never need to be formed
// - pipeline: an accepted matrix word passes through four register stages
//   (multiply, min/max, sum and round, saturate and select) before its box
//   word is valid
// - throughput: one word per cycle while box_ready does not stall the pipeline
// - reset: pipeline empties, registers return to mode none and a zero box
// - stall: a held box word keeps its value; the pipeline fills behind it
//   and xform_ready drops only once all four stages hold a word
module aabb_affine_transform import aat_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        xform_valid,
  output logic        xform_ready,
  input  xform_t      xform,
  output logic        box_valid,
  input  logic        box_ready,
  output box_t        box,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t  cfg;
  logic  span_valid;
  logic  span_ready;
  span_t span;

  assign cfg_ready = 1'b1;

  aat_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  aat_corner_span u_span (
    .clk      (clk),
    .rst      (rst),
    .up_valid (xform_valid),
    .up_ready (xform_ready),
    .up_word  (xform),
    .cfg      (cfg),
    .dn_valid (span_valid),
    .dn_ready (span_ready),
    .dn_word  (span)
  );

  aat_round_sat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round (
    .clk      (clk),
    .rst      (rst),
    .up_valid (span_valid),
    .up_ready (span_ready),
    .up_word  (span),
    .cfg      (cfg),
    .dn_valid (box_valid),
    .dn_ready (box_ready),
    .dn_word  (box)
  );

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    box_valid && box.box_empty |->
      box.world_min_x == '0 && box.world_min_y == '0 && box.world_min_z == '0 &&
      box.world_max_x == '0 && box.world_max_y == '0 && box.world_max_z == '0)
    else $error("empty box word carries non-zero bounds");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !xform_ready |-> box_valid && !box_ready)
    else $error("input held off while output side is free");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !box_valid)
    else $error("box word valid right after reset");

  a_full_ordered: assert property (@(posedge clk) disable iff (rst)
    span_valid && span_ready |->
      $signed(span.lo_term[0][0]) <= $signed(span.hi_term[0][0]) &&
      $signed(span.lo_term[1][1]) <= $signed(span.hi_term[1][1]) &&
      $signed(span.lo_term[2][2]) <= $signed(span.hi_term[2][2]))
    else $error("term minimum above term maximum");

endmodule

// ----- bench/aabb_affine_transform_tb.sv -----
`timescale 1ns / 1ps
// aabb_affine_transform_tb: self-checking bench for the world-space box block;
// drives matrix words and register writes, predicts every box word and checks it
// depends on aat_pkg and aabb_affine_transform
module aabb_affine_transform_tb;
  import aat_pkg::*;

  localparam int FRAC = 16;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int MAX_LOGGED = 40;
  localparam fix_t ONE = 32'sh0001_0000;
  localparam fix_t HALF = 32'sh0000_8000;

  class box_scoreboard;
    logic [1:0] mode = MODE_NONE;
    fix_t lo[3] = '{32'sd0, 32'sd0, 32'sd0};
    fix_t hi[3] = '{32'sd0, 32'sd0, 32'sd0};
    box_t box_q[$];
    int errors = 0;
    int logged = 0;

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_CULL_MODE: mode = data[1:0];
        REG_LOCAL_MIN_X, REG_LOCAL_MIN_Y, REG_LOCAL_MIN_Z: lo[idx - REG_LOCAL_MIN_X] = data;
        REG_LOCAL_MAX_X, REG_LOCAL_MAX_Y, REG_LOCAL_MAX_Z: hi[idx - REG_LOCAL_MAX_X] = data;
        default: ;
      endcase
    endfunction

    function fix_t clamp(logic signed [67:0] v);
      logic signed [67:0] top;
      logic signed [67:0] bottom;
      top = FIX_MAX;
      bottom = FIX_MIN;
      if (v > top) return FIX_MAX;
      if (v < bottom) return FIX_MIN;
      return v[31:0];
    endfunction

    function void note_xform(xform_t x);
      fix_t m[3][3];
      fix_t t[3];
      fix_t c[3];
      fix_t mn[3];
      fix_t mx[3];
      fix_t w;
      box_t b;
      logic signed [67:0] s;
      logic signed [67:0] a;
      logic signed [67:0] p;
      m = '{'{x.m00, x.m01, x.m02}, '{x.m10, x.m11, x.m12}, '{x.m20, x.m21, x.m22}};
      t = '{x.tx, x.ty, x.tz};
      mn = '{32'sd0, 32'sd0, 32'sd0};
      mx = '{32'sd0, 32'sd0, 32'sd0};
      b = '0;
      case (mode)
        MODE_POSITION: begin
          for (int r = 0; r < 3; r++) begin
            p = t[r];
            a = lo[r];
            mn[r] = clamp(a + p);
            a = hi[r];
            mx[r] = clamp(a + p);
          end
        end
        MODE_FULL: begin
          for (int k = 0; k < 8; k++) begin
            c[0] = ((k & 4) != 0) ? hi[0] : lo[0];
            c[1] = ((k & 2) != 0) ? hi[1] : lo[1];
            c[2] = ((k & 1) != 0) ? hi[2] : lo[2];
            for (int r = 0; r < 3; r++) begin
              // round half up at the fraction point, then add translation
              s = 68'sd1 <<< (FRAC - 1);
              for (int i = 0; i < 3; i++) begin
                a = m[r][i];
                p = c[i];
                s = s + a * p;
              end
              s = s >>> FRAC;
              a = t[r];
              w = clamp(s + a);
              if (k == 0 || w < mn[r]) mn[r] = w;
              if (k == 0 || w > mx[r]) mx[r] = w;
            end
          end
        end
        default: b.box_empty = 1'b1;
      endcase
      b.world_min_x = mn[0];
      b.world_min_y = mn[1];
      b.world_min_z = mn[2];
      b.world_max_x = mx[0];
      b.world_max_y = mx[1];
      b.world_max_z = mx[2];
      box_q.push_back(b);
    endfunction

    function int pending();
      return box_q.size();
    endfunction

    task report(string msg);
      if (logged < MAX_LOGGED) $display("ERROR %0t: %0s", $time, msg);
      logged++;
      errors++;
    endtask

    task compare(string name, fix_t got, fix_t want);
      if (got !== want) report($sformatf("%0s got %h expected %h", name, got, want));
    endtask

    task check_box(box_t got);
      box_t want;
      if (box_q.size() == 0) begin
        report("box word with no matrix word outstanding");
        return;
      end
      want = box_q.pop_front();
      compare("world_min_x", got.world_min_x, want.world_min_x);
      compare("world_min_y", got.world_min_y, want.world_min_y);
      compare("world_min_z", got.world_min_z, want.world_min_z);
      compare("world_max_x", got.world_max_x, want.world_max_x);
      compare("world_max_y", got.world_max_y, want.world_max_y);
      compare("world_max_z", got.world_max_z, want.world_max_z);
      compare("box_empty", {31'b0, got.box_empty}, {31'b0, want.box_empty});
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic xform_valid = 1'b0;
  logic xform_ready;
  xform_t xform = '0;
  logic box_valid;
  logic box_ready = 1'b0;
  box_t box;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_CULL_MODE;
  logic [31:0] cfg_data = '0;

  int send_idle = 15;
  int recv_idle = 46;
  box_scoreboard sb;

  aabb_affine_transform #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .xform_valid(xform_valid),
    .xform_ready(xform_ready),
    .xform(xform),
    .box_valid(box_valid),
    .box_ready(box_ready),
    .box(box),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // box word receiver
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && box_valid && box_ready) sb.check_box(box);
      box_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_xform(xform_t x);
    if ($urandom_range(99) < send_idle) begin
      xform_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    xform_valid <= 1'b1;
    xform <= x;
    do @(posedge clk); while (!xform_ready);
    sb.note_xform(x);
  endtask

  task automatic drain();
    xform_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic load_box(logic [1:0] mode, fix_t [2:0] lo, fix_t [2:0] hi);
    logic [31:0] word;
    word = $urandom;
    word[1:0] = mode;
    write_reg(REG_CULL_MODE, word);
    for (int i = 0; i < 3; i++) begin
      write_reg(3'(REG_LOCAL_MIN_X + i), lo[i]);
      write_reg(3'(REG_LOCAL_MAX_X + i), hi[i]);
    end
    if ($urandom_range(1) == 0) write_reg(REG_SPARE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic xform_t xf(fix_t d, fix_t o, fix_t t);
    xform_t x;
    x = '{d, o, o, t, o, d, o, t, o, o, d, t};
    return x;
  endfunction

  function automatic fix_t pick_span(int bits);
    return fix_t'(int'($urandom_range(0, 2 * (1 << bits))) - (1 << bits));
  endfunction

  function automatic fix_t pick_edge();
    case ($urandom_range(5))
      0: return FIX_MAX;
      1: return FIX_MIN;
      2: return '0;
      3: return 32'sd1;
      4: return -32'sd1;
      default: return fix_t'($urandom);
    endcase
  endfunction

  function automatic fix_t pick_bound();
    int k;
    k = $urandom_range(9);
    if (k < 6) return pick_span(20);
    if (k < 8) return fix_t'($urandom);
    return pick_edge();
  endfunction

  function automatic xform_t rand_xform();
    xform_t x;
    fix_t v;
    int kind;
    kind = $urandom_range(19);
    x = '0;
    for (int i = 0; i < 12; i++) begin
      if (kind < 14) v = (i % 4 == 3) ? pick_span(24) : pick_span(17);
      else if (kind < 17) v = fix_t'($urandom);
      else if (kind < 19) v = pick_edge();
      else v = '0;
      x[383 - 32 * i -: 32] = v;
    end
    return x;
  endfunction

  initial begin
    fix_t [2:0] lo;
    fix_t [2:0] hi;
    fix_t tmp;
    logic [1:0] mode;
    sb = new;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset state: mode none
    send_xform(xf(FIX_MAX, FIX_MIN, FIX_MAX));
    drain();

    // unknown mode, spare register write
    write_reg(REG_CULL_MODE, {30'h2AAA_AAAA, MODE_UNUSED});
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_xform(xf(ONE, '0, ONE));
    drain();

    // position only, saturation both ways
    load_box(MODE_POSITION, {3{FIX_MIN}}, {3{FIX_MAX}});
    send_xform(xf('0, '0, FIX_MAX));
    send_xform(xf('0, '0, FIX_MIN));
    send_xform(xf('0, '0, '0));
    send_xform(xf(ONE, '0, -32'sd1));
    drain();

    // position only, min above max
    load_box(MODE_POSITION, {3{ONE}}, {3{-ONE}});
    send_xform(xf('0, '0, 32'sh0003_0000));
    drain();

    // full box, unit cube
    load_box(MODE_FULL, {3{-ONE}}, {3{ONE}});
    send_xform(xf(ONE, '0, '0));
    send_xform(xf(32'sd46341, 32'sd46341, ONE));
    send_xform(xf(-ONE, '0, '0));
    send_xform(xf(FIX_MAX, FIX_MAX, FIX_MIN));
    send_xform(xf(FIX_MIN, FIX_MIN, FIX_MAX));
    drain();

    // rounding ties toward plus infinity
    load_box(MODE_FULL, {3{HALF}}, {3{HALF}});
    send_xform(xf(32'sd1, '0, '0));
    send_xform(xf(-32'sd1, '0, '0));
    send_xform(xf(-32'sd1, -32'sd1, -32'sd7));
    drain();

    // full box, extreme bounds
    load_box(MODE_FULL, {3{FIX_MIN}}, {3{FIX_MAX}});
    send_xform(xf(FIX_MAX, FIX_MIN, FIX_MAX));
    send_xform(xf(FIX_MIN, FIX_MIN, FIX_MIN));
    send_xform(xf('0, '0, FIX_MIN));
    drain();

    // full box, min above max
    load_box(MODE_FULL, {3{32'sh0002_0000}}, {3{-ONE}});
    send_xform(xf(ONE, HALF, 32'sh100));
    drain();

    for (int seg = 0; seg < 27; seg++) begin
      if (seg < 9) begin
        send_idle = 15;
        recv_idle = 46;
      end else if (seg < 18) begin
        send_idle = 46;
        recv_idle = 15;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case ($urandom_range(9))
        0: mode = MODE_NONE;
        1: mode = MODE_UNUSED;
        2, 3, 4: mode = MODE_POSITION;
        default: mode = MODE_FULL;
      endcase
      if (seg == 0) mode = MODE_NONE;
      for (int i = 0; i < 3; i++) begin
        lo[i] = pick_bound();
        hi[i] = pick_bound();
        if ($urandom_range(3) != 0 && lo[i] > hi[i]) begin
          tmp = lo[i];
          lo[i] = hi[i];
          hi[i] = tmp;
        end
      end
      load_box(mode, lo, hi);
      for (int n = 0; n < 50; n++) send_xform(rand_xform());
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
